// File: hdl/gepc_pkg.sv
package gepc_pkg;

    localparam int MAX_DIM_DEF   = 64;
    localparam int MAX_MOVES_DEF = 64;

    localparam int DIM_W   = 7;
    localparam int START_W = 6;
    localparam int COUNT_W = 30;

    localparam logic [COUNT_W-1:0] MODULUS = 30'd1000000007;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RD_V,
        ST_RD_H,
        ST_ADD_H,
        ST_WR,
        ST_RD_RES,
        ST_CAP_MEM,
        ST_CAP_ONE,
        ST_CAP_ZERO
    } state_t;

    typedef enum logic [1:0] {
        RD_VERT,
        RD_HORZ,
        RD_START
    } rd_sel_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_ONE,
        CAP_ZERO,
        CAP_MEM
    } cap_sel_t;

    typedef struct packed {
        logic     load;
        logic     init;
        rd_sel_t  rd_sel;
        logic     sum_v;
        logic     sum_h;
        logic     write;
        cap_sel_t cap_sel;
    } cmd_t;

    typedef struct packed {
        logic outside;
        logic budget_zero;
        logic last_cell;
        logic last_layer;
        logic out_free;
    } status_t;

    function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        logic [COUNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, MODULUS};
        if (s >= {1'b0, MODULUS})
        begin
            return d[COUNT_W-1:0];
        end
        return s[COUNT_W-1:0];
    endfunction

    // neighbour contribution: off-grid walks exit, layer one sees an empty plane
    function automatic logic [COUNT_W-1:0] nb_value(input logic [COUNT_W-1:0] data,
                                                    input logic on_grid,
                                                    input logic first);
        if (!on_grid)
        begin
            return COUNT_W'(1);
        end
        if (first)
        begin
            return '0;
        end
        return data;
    endfunction

endpackage

// File: hdl/gepc_ctrl.sv
module gepc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  gepc_pkg::status_t status,
    output gepc_pkg::cmd_t    cmd
);

    gepc_pkg::state_t state_reg;
    gepc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gepc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gepc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gepc_pkg::ST_SETUP;
                end
            end
            gepc_pkg::ST_SETUP:
            begin
                if (status.outside)
                begin
                    state_next = gepc_pkg::ST_CAP_ONE;
                end
                else if (status.budget_zero)
                begin
                    state_next = gepc_pkg::ST_CAP_ZERO;
                end
                else
                begin
                    state_next = gepc_pkg::ST_RD_V;
                end
            end
            gepc_pkg::ST_RD_V:  state_next = gepc_pkg::ST_RD_H;
            gepc_pkg::ST_RD_H:  state_next = gepc_pkg::ST_ADD_H;
            gepc_pkg::ST_ADD_H: state_next = gepc_pkg::ST_WR;
            gepc_pkg::ST_WR:
            begin
                if (status.last_cell && status.last_layer)
                begin
                    state_next = gepc_pkg::ST_RD_RES;
                end
                else
                begin
                    state_next = gepc_pkg::ST_RD_V;
                end
            end
            gepc_pkg::ST_RD_RES: state_next = gepc_pkg::ST_CAP_MEM;
            gepc_pkg::ST_CAP_MEM,
            gepc_pkg::ST_CAP_ONE,
            gepc_pkg::ST_CAP_ZERO:
            begin
                if (status.out_free)
                begin
                    state_next = gepc_pkg::ST_IDLE;
                end
            end
            default: state_next = gepc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        cmd.load    = 1'b0;
        cmd.init    = 1'b0;
        cmd.rd_sel  = gepc_pkg::RD_VERT;
        cmd.sum_v   = 1'b0;
        cmd.sum_h   = 1'b0;
        cmd.write   = 1'b0;
        cmd.cap_sel = gepc_pkg::CAP_NONE;
        case (state_reg)
            gepc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            gepc_pkg::ST_SETUP:  cmd.init = 1'b1;
            gepc_pkg::ST_RD_V:   cmd.rd_sel = gepc_pkg::RD_VERT;
            gepc_pkg::ST_RD_H:
            begin
                cmd.rd_sel = gepc_pkg::RD_HORZ;
                cmd.sum_v  = 1'b1;
            end
            gepc_pkg::ST_ADD_H:  cmd.sum_h = 1'b1;
            gepc_pkg::ST_WR:     cmd.write = 1'b1;
            gepc_pkg::ST_RD_RES: cmd.rd_sel = gepc_pkg::RD_START;
            gepc_pkg::ST_CAP_MEM:
            begin
                // keep re-reading the start cell while the output is busy
                cmd.rd_sel = gepc_pkg::RD_START;
                if (status.out_free)
                begin
                    cmd.cap_sel = gepc_pkg::CAP_MEM;
                end
            end
            gepc_pkg::ST_CAP_ONE:
            begin
                if (status.out_free)
                begin
                    cmd.cap_sel = gepc_pkg::CAP_ONE;
                end
            end
            gepc_pkg::ST_CAP_ZERO:
            begin
                if (status.out_free)
                begin
                    cmd.cap_sel = gepc_pkg::CAP_ZERO;
                end
            end
            default: in_stall = 1'b1;
        endcase
    end

endmodule

// File: hdl/gepc_datapath.sv
module gepc_datapath
#(
    parameter int MAX_DIM   = gepc_pkg::MAX_DIM_DEF,
    parameter int MAX_MOVES = gepc_pkg::MAX_MOVES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  gepc_pkg::cmd_t               cmd,
    output gepc_pkg::status_t            status,
    input  logic [gepc_pkg::DIM_W-1:0]   rows,
    input  logic [gepc_pkg::DIM_W-1:0]   cols,
    input  logic [gepc_pkg::DIM_W-1:0]   move_budget,
    input  logic [gepc_pkg::START_W-1:0] start_row,
    input  logic [gepc_pkg::START_W-1:0] start_col,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [gepc_pkg::COUNT_W-1:0] path_count
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int BW    = $clog2(MAX_MOVES + 1);
    localparam int AW    = 1 + 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = gepc_pkg::COUNT_W;

    logic [CW-1:0] mem [DEPTH];

    logic [DW-1:0]                rows_reg;
    logic [DW-1:0]                cols_reg;
    logic [BW-1:0]                budget_reg;
    logic [gepc_pkg::START_W-1:0] srow_reg;
    logic [gepc_pkg::START_W-1:0] scol_reg;

    logic [IW-1:0] r_reg;
    logic [IW-1:0] c_reg;
    logic [BW-1:0] layer_reg;
    logic          cur_reg;

    logic [CW-1:0] rd_a_reg;
    logic [CW-1:0] rd_b_reg;
    logic          in_a_reg;
    logic          in_b_reg;
    logic [CW-1:0] v_sum_reg;
    logic [CW-1:0] h_sum_reg;
    logic [CW-1:0] path_count_reg;
    logic          out_valid_reg;

    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] addr_w;
    logic          in_a;
    logic          in_b;
    logic          up_in;
    logic          dn_in;
    logic          lt_in;
    logic          rt_in;
    logic          last_col;
    logic          last_row;
    logic          first;
    logic [CW-1:0] pair_sum;
    logic [CW-1:0] total;

    assign up_in    = (r_reg != '0);
    assign dn_in    = ((DW'(r_reg) + DW'(1)) < rows_reg);
    assign lt_in    = (c_reg != '0);
    assign rt_in    = ((DW'(c_reg) + DW'(1)) < cols_reg);
    assign last_col = ((DW'(c_reg) + DW'(1)) == cols_reg);
    assign last_row = ((DW'(r_reg) + DW'(1)) == rows_reg);
    assign first    = (layer_reg == BW'(1));

    always_comb
    begin
        addr_a = {cur_reg, r_reg - IW'(1), c_reg};
        addr_b = {cur_reg, r_reg + IW'(1), c_reg};
        in_a   = up_in;
        in_b   = dn_in;
        case (cmd.rd_sel)
            gepc_pkg::RD_VERT:
            begin
                addr_a = {cur_reg, r_reg - IW'(1), c_reg};
                addr_b = {cur_reg, r_reg + IW'(1), c_reg};
                in_a   = up_in;
                in_b   = dn_in;
            end
            gepc_pkg::RD_HORZ:
            begin
                addr_a = {cur_reg, r_reg, c_reg - IW'(1)};
                addr_b = {cur_reg, r_reg, c_reg + IW'(1)};
                in_a   = lt_in;
                in_b   = rt_in;
            end
            gepc_pkg::RD_START:
            begin
                addr_a = {cur_reg, IW'(srow_reg), IW'(scol_reg)};
                addr_b = {cur_reg, IW'(srow_reg), IW'(scol_reg)};
                in_a   = 1'b1;
                in_b   = 1'b1;
            end
            default:
            begin
                in_a = 1'b0;
                in_b = 1'b0;
            end
        endcase
    end

    assign addr_w   = {~cur_reg, r_reg, c_reg};
    assign pair_sum = gepc_pkg::mod_add(gepc_pkg::nb_value(rd_a_reg, in_a_reg, first),
                                        gepc_pkg::nb_value(rd_b_reg, in_b_reg, first));
    assign total    = gepc_pkg::mod_add(v_sum_reg, h_sum_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[addr_w] <= total;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        in_a_reg <= in_a;
        in_b_reg <= in_b;
        if (cmd.load)
        begin
            rows_reg   <= (rows > MAX_DIM) ? DW'(MAX_DIM) : DW'(rows);
            cols_reg   <= (cols > MAX_DIM) ? DW'(MAX_DIM) : DW'(cols);
            budget_reg <= (move_budget > MAX_MOVES) ? BW'(MAX_MOVES) : BW'(move_budget);
            srow_reg   <= start_row;
            scol_reg   <= start_col;
        end
        if (cmd.sum_v)
        begin
            v_sum_reg <= pair_sum;
        end
        if (cmd.sum_h)
        begin
            h_sum_reg <= pair_sum;
        end
        if (cmd.init)
        begin
            r_reg     <= '0;
            c_reg     <= '0;
            layer_reg <= BW'(1);
            cur_reg   <= 1'b0;
        end
        else if (cmd.write)
        begin
            if (last_col && last_row)
            begin
                r_reg   <= '0;
                c_reg   <= '0;
                cur_reg <= ~cur_reg;
                if (layer_reg != budget_reg)
                begin
                    layer_reg <= layer_reg + BW'(1);
                end
            end
            else if (last_col)
            begin
                c_reg <= '0;
                r_reg <= r_reg + IW'(1);
            end
            else
            begin
                c_reg <= c_reg + IW'(1);
            end
        end
        case (cmd.cap_sel)
            gepc_pkg::CAP_ONE:  path_count_reg <= CW'(1);
            gepc_pkg::CAP_ZERO: path_count_reg <= '0;
            gepc_pkg::CAP_MEM:  path_count_reg <= rd_a_reg;
            default:            path_count_reg <= path_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.cap_sel != gepc_pkg::CAP_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.outside     = (DW'(1) > rows_reg) || (DW'(1) > cols_reg)
                                || ({{DW{1'b0}}, srow_reg} >= {{gepc_pkg::START_W{1'b0}}, rows_reg})
                                || ({{DW{1'b0}}, scol_reg} >= {{gepc_pkg::START_W{1'b0}}, cols_reg});
    assign status.budget_zero = (budget_reg == '0);
    assign status.last_cell   = last_col && last_row;
    assign status.last_layer  = (layer_reg == budget_reg);
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign path_count = path_count_reg;

endmodule

// File: hdl/grid_exit_path_counter_core.sv
// channel  | handshake           | payload
// ---------+---------------------+---------------------------------------------------
// input    | in_valid / in_stall | rows, cols, move_budget, start_row, start_col
// output   | out_valid/out_stall | path_count
//
// A query inside the grid passes each cell of each layer through four steps on the
// two-read-port plane memory (vertical pair read, horizontal pair read, add, write).
// Starts off the grid or a zero budget skip the sweep. Planes need no clearing:
// layer one treats in-grid neighbours as zero. Reset is asynchronous, active low.
// The result beat sits in an output register, so a new query is taken while it
// waits; a query finishing early holds on stall.
module grid_exit_path_counter_core
#(
    parameter int MAX_DIM   = gepc_pkg::MAX_DIM_DEF,
    parameter int MAX_MOVES = gepc_pkg::MAX_MOVES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [gepc_pkg::DIM_W-1:0]   rows,
    input  logic [gepc_pkg::DIM_W-1:0]   cols,
    input  logic [gepc_pkg::DIM_W-1:0]   move_budget,
    input  logic [gepc_pkg::START_W-1:0] start_row,
    input  logic [gepc_pkg::START_W-1:0] start_col,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [gepc_pkg::COUNT_W-1:0] path_count
);

    gepc_pkg::cmd_t    cmd;
    gepc_pkg::status_t status;

    gepc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gepc_datapath
    #(
        .MAX_DIM   (MAX_DIM),
        .MAX_MOVES (MAX_MOVES)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .rows        (rows),
        .cols        (cols),
        .move_budget (move_budget),
        .start_row   (start_row),
        .start_col   (start_col),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .path_count  (path_count)
    );

endmodule

// File: verif/grid_exit_path_counter_core_test.sv
`timescale 1ns / 100ps

module grid_exit_path_counter_core_test;

    class exit_count_board;
        bit [gepc_pkg::COUNT_W-1:0] pending_counts[$];
        int                         failures;
        int unsigned                plane [2][gepc_pkg::MAX_DIM_DEF][gepc_pkg::MAX_DIM_DEF];

        function longint unsigned neighbour_term(int cur, int r, int c, int nr, int nc);
            if (r < 0 || c < 0 || r >= nr || c >= nc)
            begin
                return 1;
            end
            return longint'(plane[cur][r][c]);
        endfunction

        // bottom-up over moves left; layer 0 is all zero
        function bit [gepc_pkg::COUNT_W-1:0] count_exit_walks(int nr, int nc, int nb,
                                                              int sr, int sc);
            int               cur;
            longint unsigned  sum;
            if (nr > gepc_pkg::MAX_DIM_DEF)
            begin
                nr = gepc_pkg::MAX_DIM_DEF;
            end
            if (nc > gepc_pkg::MAX_DIM_DEF)
            begin
                nc = gepc_pkg::MAX_DIM_DEF;
            end
            if (nb > gepc_pkg::MAX_MOVES_DEF)
            begin
                nb = gepc_pkg::MAX_MOVES_DEF;
            end
            if (sr >= nr || sc >= nc)
            begin
                return 1;
            end
            cur = 0;
            for (int r = 0; r < nr; r++)
            begin
                for (int c = 0; c < nc; c++)
                begin
                    plane[0][r][c] = 0;
                end
            end
            for (int k = 1; k <= nb; k++)
            begin
                for (int r = 0; r < nr; r++)
                begin
                    for (int c = 0; c < nc; c++)
                    begin
                        sum = neighbour_term(cur, r + 1, c, nr, nc)
                            + neighbour_term(cur, r - 1, c, nr, nc)
                            + neighbour_term(cur, r, c + 1, nr, nc)
                            + neighbour_term(cur, r, c - 1, nr, nc);
                        plane[cur ^ 1][r][c] = 32'(sum % longint'(gepc_pkg::MODULUS));
                    end
                end
                cur = cur ^ 1;
            end
            return gepc_pkg::COUNT_W'(plane[cur][sr][sc]);
        endfunction

        function void note_query(int r, int c, int b, int sr, int sc);
            pending_counts.push_back(count_exit_walks(r, c, b, sr, sc));
        endfunction

        function void check_count(bit [gepc_pkg::COUNT_W-1:0] actual);
            bit [gepc_pkg::COUNT_W-1:0] wanted;
            if (pending_counts.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("path_count %0d with no query outstanding", actual);
                end
                return;
            end
            wanted = pending_counts.pop_front();
            if (wanted != actual)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("path_count mismatch: expected %0d, got %0d", wanted, actual);
                end
            end
        endfunction
    endclass

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic [gepc_pkg::DIM_W-1:0]     rows        = '0;
    logic [gepc_pkg::DIM_W-1:0]     cols        = '0;
    logic [gepc_pkg::DIM_W-1:0]     move_budget = '0;
    logic [gepc_pkg::START_W-1:0]   start_row   = '0;
    logic [gepc_pkg::START_W-1:0]   start_col   = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic [gepc_pkg::COUNT_W-1:0]   path_count;

    logic                 recv_hold     = 1'b0;
    int                   send_idle_pct = 38;
    int                   recv_idle_pct = 81;
    exit_count_board      board;

    grid_exit_path_counter_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rows        (rows),
        .cols        (cols),
        .move_budget (move_budget),
        .start_row   (start_row),
        .start_col   (start_col),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .path_count  (path_count)
    );

    always
    begin
        #5ns clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_count(path_count);
        end
        out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic offer_query(input int r, input int c, input int b, input int sr, input int sc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        rows        <= gepc_pkg::DIM_W'(r);
        cols        <= gepc_pkg::DIM_W'(c);
        move_budget <= gepc_pkg::DIM_W'(b);
        start_row   <= gepc_pkg::START_W'(sr);
        start_col   <= gepc_pkg::START_W'(sc);
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        board.note_query(r, c, b, sr, sc);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic hold_receiver(input int span);
        recv_hold <= 1'b1;
        repeat (span) @(posedge clk);
        recv_hold <= 1'b0;
    endtask

    task automatic offer_random_queries(input int count);
        int pick;
        int r;
        int c;
        int b;
        int sr;
        int sc;
        for (int n = 0; n < count; n++)
        begin
            pick = int'($urandom_range(99));
            if (pick < 55)
            begin
                r  = int'($urandom_range(8, 1));
                c  = int'($urandom_range(8, 1));
                b  = int'($urandom_range(24, 0));
                sr = int'($urandom_range(r - 1, 0));
                sc = int'($urandom_range(c - 1, 0));
            end
            else if (pick < 65)
            begin
                // start off the grid
                r  = int'($urandom_range(127, 0));
                c  = int'($urandom_range(127, 0));
                b  = int'($urandom_range(127, 0));
                sr = int'($urandom_range(63, 0));
                sc = int'($urandom_range(63, 0));
                if (sr < r && sc < c)
                begin
                    if ($urandom_range(1))
                    begin
                        r = int'($urandom_range(sr, 0));
                    end
                    else
                    begin
                        c = int'($urandom_range(sc, 0));
                    end
                end
            end
            else if (pick < 75)
            begin
                // narrow strip, long budget
                r  = int'($urandom_range(2, 1));
                c  = int'($urandom_range(16, 1));
                b  = int'($urandom_range(127, 25));
                sr = int'($urandom_range(r - 1, 0));
                sc = int'($urandom_range(c - 1, 0));
                if ($urandom_range(1))
                begin
                    {r, c}   = {c, r};
                    {sr, sc} = {sc, sr};
                end
            end
            else if (pick < 85)
            begin
                r  = int'($urandom_range(127, 1));
                c  = int'($urandom_range(127, 1));
                b  = int'($urandom_range(2, 0));
                sr = int'($urandom_range(63, 0));
                sc = int'($urandom_range(63, 0));
            end
            else
            begin
                r  = int'($urandom_range(127, 0));
                c  = int'($urandom_range(127, 0));
                b  = int'($urandom_range(127, 0));
                sr = int'($urandom_range(63, 0));
                sc = int'($urandom_range(63, 0));
            end
            // keep the sweep short
            while (sr < r && sc < c
                   && 4 * (r > 64 ? 64 : r) * (c > 64 ? 64 : c) * (b > 64 ? 64 : b) > 12000)
            begin
                b = b / 2;
            end
            offer_query(r, c, b, sr, sc);
        end
    endtask

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_query(1, 1, 0, 0, 0);
        offer_query(1, 1, 1, 0, 0);
        offer_query(1, 1, 127, 0, 0);
        offer_query(2, 2, 2, 0, 0);
        offer_query(1, 3, 3, 0, 1);
        offer_query(0, 5, 9, 0, 0);
        offer_query(5, 0, 9, 0, 0);
        offer_query(0, 0, 127, 63, 63);
        offer_query(10, 10, 20, 63, 2);
        offer_query(10, 10, 20, 2, 63);
        offer_query(64, 64, 0, 63, 63);
        offer_query(64, 64, 1, 63, 63);
        offer_query(127, 127, 2, 0, 0);
        offer_query(127, 1, 64, 42, 0);
        offer_query(1, 127, 100, 0, 21);
        offer_query(8, 8, 64, 3, 4);
        offer_query(3, 3, 64, 1, 1);
        offer_query(64, 63, 1, 62, 31);
        offer_query(5, 5, 5, 4, 4);
        offer_query(96, 2, 10, 63, 1);
        wait_drained();

        offer_random_queries(23);
        wait_drained();

        send_idle_pct = 81;
        recv_idle_pct = 38;
        offer_random_queries(22);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off while tiny queries keep coming
        fork
            hold_receiver(600);
        join_none
        for (int n = 0; n < 12; n++)
        begin
            offer_query(int'($urandom_range(2, 1)), int'($urandom_range(2, 1)),
                        int'($urandom_range(3, 0)), 0, 0);
        end
        wait_drained();
        offer_random_queries(23);
        wait_drained();

        repeat (50) @(posedge clk);
        if (board.failures == 0 && board.pending_counts.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end

endmodule

// File: grid_exit_path_counter_core.f
hdl/gepc_pkg.sv
hdl/gepc_ctrl.sv
hdl/gepc_datapath.sv
hdl/grid_exit_path_counter_core.sv
verif/grid_exit_path_counter_core_test.sv
